### src/tlpf_pkg.sv
// ----------------------------------------------------------------------------
// tlpf_pkg: shared types and constants of the three-level priority FIFO
// Holds request and status codes, level codes, stream widths and the
// decoded command record that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package tlpf_pkg;

  // Field widths of one request and one result.
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned AGE_W    = 7;
  localparam int unsigned NLVL_W   = 3;
  localparam int unsigned LVL_W    = 2;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned TOTAL_W  = 5;

  // Stream widths, data fields packed from bit 0 and padded to bytes.
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned S_TUSER_W = REQ_W;
  localparam int unsigned M_TDATA_W = 48;
  localparam int unsigned M_TUSER_W = STAT_W;

  // Request type codes as they arrive on the slave side.
  localparam logic [REQ_W-1:0] REQ_INSERT    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET_LEVEL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SERVE     = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BAD_LEVEL = 3'd4;

  // Entry levels; a lower code is served first.
  localparam logic [LVL_W-1:0] LVL_NONE   = 2'd0;
  localparam logic [LVL_W-1:0] LVL_HIGH   = 2'd1;
  localparam logic [LVL_W-1:0] LVL_MEDIUM = 2'd2;
  localparam logic [LVL_W-1:0] LVL_LOW    = 2'd3;

  // Depth of the command queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_SET_LEVEL,
    OP_SERVE,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [KEY_W-1:0]  key;
    logic [AGE_W-1:0]  age;
    logic [LVL_W-1:0]  level;
    logic              level_ok;
  } cmd_t;

endpackage

### src/tlpf_front.sv
// ----------------------------------------------------------------------------
// tlpf_front: request intake and classification
// Unpacks the slave stream, decodes the request type and checks the
// requested level, then pushes a command record into the queue.
// ----------------------------------------------------------------------------
module tlpf_front (
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [tlpf_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic [tlpf_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output tlpf_pkg::cmd_t                 q_cmd_o
);

  logic [tlpf_pkg::NLVL_W-1:0] req_level;

  assign s_axis_tready_o = ~q_full_i;
  assign q_push_o        = s_axis_tvalid_i & ~q_full_i;

  assign req_level = s_axis_tdata_i[41:39];

  always_comb begin
    q_cmd_o.key      = s_axis_tdata_i[31:0];
    q_cmd_o.age      = s_axis_tdata_i[38:32];
    q_cmd_o.level    = req_level[tlpf_pkg::LVL_W-1:0];
    // Only high, medium and low are legal; the top bit must be clear.
    q_cmd_o.level_ok = ~req_level[2] & (req_level[1:0] != tlpf_pkg::LVL_NONE);
    unique case (s_axis_tuser_i)
      tlpf_pkg::REQ_INSERT:    q_cmd_o.op = tlpf_pkg::OP_INSERT;
      tlpf_pkg::REQ_SET_LEVEL: q_cmd_o.op = tlpf_pkg::OP_SET_LEVEL;
      tlpf_pkg::REQ_SERVE:     q_cmd_o.op = tlpf_pkg::OP_SERVE;
      default:                 q_cmd_o.op = tlpf_pkg::OP_NONE;
    endcase
  end

endmodule

### src/tlpf_cmd_queue.sv
// ----------------------------------------------------------------------------
// tlpf_cmd_queue: short command queue
// Two-entry FIFO of decoded commands that lets the front end keep taking
// requests while the back end works or waits on its output.
// ----------------------------------------------------------------------------
module tlpf_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tlpf_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tlpf_pkg::cmd_t head_o
);

  tlpf_pkg::cmd_t                  mem_q [tlpf_pkg::QUEUE_DEPTH];
  logic [tlpf_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [tlpf_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [tlpf_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == tlpf_pkg::QCNT_W'(tlpf_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### src/tlpf_back.sv
// ----------------------------------------------------------------------------
// tlpf_back: entry store and request execution
// Keeps the entries packed oldest first in a row of cells. The idle state
// captures per-cell key matches and level flags, the pick state picks the first
// match or the best entry, updates the cells and loads the result register.
// ----------------------------------------------------------------------------
module tlpf_back #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  tlpf_pkg::cmd_t                 cmd_i,
  output logic                           cmd_pop_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [tlpf_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  output logic [tlpf_pkg::M_TUSER_W-1:0] m_axis_tuser_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CAPACITY-1:0] ONE = {{(CAPACITY-1){1'b0}}, 1'b1};

  localparam logic S_IDLE = 1'b0;
  localparam logic S_PICK = 1'b1;

  logic                          state_q, state_d;
  tlpf_pkg::cmd_t                cmd_q;

  // Entry cells.
  logic [CAPACITY-1:0]           valid_q;
  logic [tlpf_pkg::KEY_W-1:0]    key_q [CAPACITY];
  logic [tlpf_pkg::AGE_W-1:0]    age_q [CAPACITY];
  logic [tlpf_pkg::LVL_W-1:0]    lvl_q [CAPACITY];
  logic [CNT_W-1:0]              cnt_q, cnt_d;

  // Values each cell takes when later entries move down after a serve.
  logic [CAPACITY-1:0]           valid_up;
  logic [tlpf_pkg::KEY_W-1:0]    key_up [CAPACITY];
  logic [tlpf_pkg::AGE_W-1:0]    age_up [CAPACITY];
  logic [tlpf_pkg::LVL_W-1:0]    lvl_up [CAPACITY];

  // Flags captured when a command is taken from the queue.
  logic [CAPACITY-1:0]           hit_q, l1_q, l2_q, l3_q;

  logic [CAPACITY-1:0]           hit_oh, sel_vec, srv_oh, shift_mask, ins_oh;
  logic [tlpf_pkg::KEY_W-1:0]    rd_key;
  logic [tlpf_pkg::AGE_W-1:0]    rd_age;
  logic [tlpf_pkg::LVL_W-1:0]    best_lvl;
  logic                          out_free, commit;
  logic                          do_insert, do_set, do_serve;
  logic [tlpf_pkg::STAT_W-1:0]   status_d;

  // Result register.
  logic                          out_valid_q;
  logic [tlpf_pkg::STAT_W-1:0]   out_status_q;
  logic [tlpf_pkg::KEY_W-1:0]    out_key_q;
  logic [tlpf_pkg::AGE_W-1:0]    out_age_q;
  logic [tlpf_pkg::LVL_W-1:0]    out_lvl_q;
  logic [tlpf_pkg::TOTAL_W-1:0]  out_total_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_up
    if (i < CAPACITY - 1) begin : g_mid
      assign valid_up[i] = valid_q[i+1];
      assign key_up[i]   = key_q[i+1];
      assign age_up[i]   = age_q[i+1];
      assign lvl_up[i]   = lvl_q[i+1];
    end else begin : g_top
      assign valid_up[i] = 1'b0;
      assign key_up[i]   = key_q[i];
      assign age_up[i]   = age_q[i];
      assign lvl_up[i]   = lvl_q[i];
    end
  end

  assign out_free  = ~out_valid_q | m_axis_tready_i;
  assign cmd_pop_o = (state_q == S_IDLE) & cmd_valid_i;
  assign commit    = (state_q == S_PICK) & out_free;

  // Lowest set bit of each flag vector is the oldest qualifying entry.
  assign hit_oh     = hit_q & (~hit_q + ONE);
  assign sel_vec    = (|l1_q) ? l1_q : ((|l2_q) ? l2_q : l3_q);
  assign srv_oh     = sel_vec & (~sel_vec + ONE);
  assign shift_mask = ~(srv_oh - ONE);
  // Entries are packed, so the first free cell is the one at the count.
  assign ins_oh     = ~valid_q & (valid_q + ONE);
  assign best_lvl   = (|l1_q) ? tlpf_pkg::LVL_HIGH :
                      ((|l2_q) ? tlpf_pkg::LVL_MEDIUM : tlpf_pkg::LVL_LOW);

  always_comb begin
    rd_key = '0;
    rd_age = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      rd_key = rd_key | (key_q[i] & {tlpf_pkg::KEY_W{srv_oh[i]}});
      rd_age = rd_age | (age_q[i] & {tlpf_pkg::AGE_W{srv_oh[i]}});
    end
  end

  always_comb begin
    do_insert = 1'b0;
    do_set    = 1'b0;
    do_serve  = 1'b0;
    status_d  = tlpf_pkg::STAT_OK;
    case (cmd_q.op)
      tlpf_pkg::OP_INSERT: begin
        if (valid_q[CAPACITY-1]) begin
          status_d = tlpf_pkg::STAT_FULL;
        end else begin
          do_insert = commit;
        end
      end
      tlpf_pkg::OP_SET_LEVEL: begin
        // A missing key is reported ahead of a bad level.
        if (!(|hit_q)) begin
          status_d = tlpf_pkg::STAT_NOT_FOUND;
        end else if (!cmd_q.level_ok) begin
          status_d = tlpf_pkg::STAT_BAD_LEVEL;
        end else begin
          do_set = commit;
        end
      end
      tlpf_pkg::OP_SERVE: begin
        if (!(|sel_vec)) begin
          status_d = tlpf_pkg::STAT_EMPTY;
        end else begin
          do_serve = commit;
        end
      end
      default: begin
        status_d = tlpf_pkg::STAT_OK;
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (do_insert) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_serve) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (do_insert) begin
        valid_q <= valid_q | ins_oh;
      end else if (do_serve) begin
        valid_q <= (valid_q & ~shift_mask) | (valid_up & shift_mask);
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
      for (int unsigned i = 0; i < CAPACITY; i++) begin
        hit_q[i] <= valid_q[i] & (key_q[i] == cmd_i.key);
        l1_q[i]  <= valid_q[i] & (lvl_q[i] == tlpf_pkg::LVL_HIGH);
        l2_q[i]  <= valid_q[i] & (lvl_q[i] == tlpf_pkg::LVL_MEDIUM);
        l3_q[i]  <= valid_q[i] & (lvl_q[i] == tlpf_pkg::LVL_LOW);
      end
    end
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (do_insert && ins_oh[i]) begin
        key_q[i] <= cmd_q.key;
        age_q[i] <= cmd_q.age;
        lvl_q[i] <= tlpf_pkg::LVL_LOW;
      end else if (do_set && hit_oh[i]) begin
        lvl_q[i] <= cmd_q.level;
      end else if (do_serve && shift_mask[i]) begin
        key_q[i] <= key_up[i];
        age_q[i] <= age_up[i];
        lvl_q[i] <= lvl_up[i];
      end
    end
    if (commit) begin
      out_status_q <= status_d;
      out_total_q  <= tlpf_pkg::TOTAL_W'(cnt_d);
      if (do_serve) begin
        out_key_q <= rd_key;
        out_age_q <= rd_age;
        out_lvl_q <= best_lvl;
      end else begin
        out_key_q <= '0;
        out_age_q <= '0;
        out_lvl_q <= tlpf_pkg::LVL_NONE;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {2'b00, out_total_q, out_lvl_q, out_age_q, out_key_q};

endmodule

### src/three_level_priority_fifo.sv
// A request accepted on the slave side is written into the command queue. The back
// end pops it in its idle state, capturing per-entry key and level flags, and commits it
// in its pick state once the output is free, loading the result register that drives the
// master side. It finishes one request before taking the next, and a two-entry command
// queue lets the slave side keep accepting meanwhile.
// Reset: asynchronous, active low; clears entry valid bits, the count, queue pointers and result valid bit.
// ----------------------------------------------------------------------------
// three_level_priority_fifo: strict priority queue with three levels
// Inserts at low level, re-levels the oldest entry with a given key, and
// serves the oldest entry of the highest level present.
// ----------------------------------------------------------------------------
module three_level_priority_fifo #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // patient_key[31:0], patient_age[38:32], new_level[41:39], zero pad
  input  logic [tlpf_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [tlpf_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // served_key[31:0], served_age[38:32], served_level[40:39],
  // entry_total[45:41], zero pad
  output logic [tlpf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status[2:0]
  output logic [tlpf_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  logic           q_full, q_push, q_valid, q_pop;
  tlpf_pkg::cmd_t q_push_cmd, q_head;

  tlpf_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (q_push_cmd)
  );

  tlpf_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  tlpf_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (q_head),
    .cmd_pop_o       (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

endmodule

### bench/tlpf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlpf_checker: scoreboard for the three-level priority FIFO
// Watches both stream channels. Every accepted request is run through a
// behavioral copy of the queue to build the result it must produce. Every
// accepted result is compared field by field with the oldest such result.
// ----------------------------------------------------------------------------
module tlpf_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // patient_key[31:0], patient_age[38:32], new_level[41:39], zero pad
  input  logic [tlpf_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [tlpf_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // served_key[31:0], served_age[38:32], served_level[40:39],
  // entry_total[45:41], zero pad
  input  logic [tlpf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status[2:0]
  input  logic [tlpf_pkg::M_TUSER_W-1:0] m_axis_tuser,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    result_count_o,
  output int unsigned                    served_count_o,
  output int unsigned                    full_count_o,
  output int unsigned                    empty_count_o,
  output int unsigned                    miss_count_o,
  output int unsigned                    bad_level_count_o
);

  localparam int unsigned KEY_LO = 0;
  localparam int unsigned AGE_LO = tlpf_pkg::KEY_W;
  localparam int unsigned LVL_LO = tlpf_pkg::KEY_W + tlpf_pkg::AGE_W;
  localparam int unsigned TOT_LO = tlpf_pkg::KEY_W + tlpf_pkg::AGE_W + tlpf_pkg::LVL_W;

  typedef struct packed {
    logic [tlpf_pkg::KEY_W-1:0] key;
    logic [tlpf_pkg::AGE_W-1:0] age;
    logic [tlpf_pkg::LVL_W-1:0] level;
  } entry_t;

  typedef struct packed {
    logic [tlpf_pkg::STAT_W-1:0]  status;
    logic [tlpf_pkg::KEY_W-1:0]   key;
    logic [tlpf_pkg::AGE_W-1:0]   age;
    logic [tlpf_pkg::LVL_W-1:0]   level;
    logic [tlpf_pkg::TOTAL_W-1:0] total;
  } outcome_t;

  // Live entries, oldest first, as the block keeps them.
  entry_t   held[$];
  outcome_t awaited[$];

  int unsigned fails;
  int unsigned results;
  int unsigned served;
  int unsigned fulls;
  int unsigned empties;
  int unsigned misses;
  int unsigned bad_levels;

  // Updates the queue copy with one request and returns the result it causes.
  function automatic outcome_t apply_request(input logic [tlpf_pkg::REQ_W-1:0]  req,
                                             input logic [tlpf_pkg::KEY_W-1:0]  key,
                                             input logic [tlpf_pkg::AGE_W-1:0]  age,
                                             input logic [tlpf_pkg::NLVL_W-1:0] nlvl);
    outcome_t res;
    entry_t   fresh;
    int       pick;
    res = '0;
    res.status = tlpf_pkg::STAT_OK;
    case (req)
      tlpf_pkg::REQ_INSERT: begin
        if (held.size() >= CAPACITY) begin
          res.status = tlpf_pkg::STAT_FULL;
        end else begin
          fresh.key   = key;
          fresh.age   = age;
          fresh.level = tlpf_pkg::LVL_LOW;
          held.push_back(fresh);
        end
      end
      tlpf_pkg::REQ_SET_LEVEL: begin
        // Only the oldest entry with the key is touched, and a missing key
        // wins over a bad level.
        pick = -1;
        for (int i = 0; i < held.size(); i++) begin
          if (pick < 0 && held[i].key == key) pick = i;
        end
        if (pick < 0) begin
          res.status = tlpf_pkg::STAT_NOT_FOUND;
        end else if (nlvl < tlpf_pkg::LVL_HIGH || nlvl > tlpf_pkg::LVL_LOW) begin
          res.status = tlpf_pkg::STAT_BAD_LEVEL;
        end else begin
          fresh = held[pick];
          fresh.level = nlvl[tlpf_pkg::LVL_W-1:0];
          held[pick] = fresh;
        end
      end
      tlpf_pkg::REQ_SERVE: begin
        if (held.size() == 0) begin
          res.status = tlpf_pkg::STAT_EMPTY;
        end else begin
          // Strict less-than keeps the oldest entry among equal levels.
          pick = 0;
          for (int i = 1; i < held.size(); i++) begin
            if (held[i].level < held[pick].level) pick = i;
          end
          res.key   = held[pick].key;
          res.age   = held[pick].age;
          res.level = held[pick].level;
          held.delete(pick);
        end
      end
      default: begin
      end
    endcase
    res.total = tlpf_pkg::TOTAL_W'(held.size());
    return res;
  endfunction

  task automatic check_field(input string name, input logic [tlpf_pkg::KEY_W-1:0] want,
                             input logic [tlpf_pkg::KEY_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    outcome_t want;
    outcome_t got;
    if (!rst_ni) begin
      held.delete();
      awaited.delete();
    end else begin
      // Results are matched before the new request is queued, since a request
      // taken at this edge cannot have its result out yet.
      if (m_axis_tvalid && m_axis_tready) begin
        results++;
        got.status = m_axis_tuser;
        got.key    = m_axis_tdata[KEY_LO +: tlpf_pkg::KEY_W];
        got.age    = m_axis_tdata[AGE_LO +: tlpf_pkg::AGE_W];
        got.level  = m_axis_tdata[LVL_LO +: tlpf_pkg::LVL_W];
        got.total  = m_axis_tdata[TOT_LO +: tlpf_pkg::TOTAL_W];
        if (awaited.size() == 0) begin
          $error("result with no request pending: status %0d", got.status);
          fails++;
        end else begin
          want = awaited.pop_front();
          check_field("status", tlpf_pkg::KEY_W'(want.status),
                      tlpf_pkg::KEY_W'(got.status));
          check_field("served_key", want.key, got.key);
          check_field("served_age", tlpf_pkg::KEY_W'(want.age),
                      tlpf_pkg::KEY_W'(got.age));
          check_field("served_level", tlpf_pkg::KEY_W'(want.level),
                      tlpf_pkg::KEY_W'(got.level));
          check_field("entry_total", tlpf_pkg::KEY_W'(want.total),
                      tlpf_pkg::KEY_W'(got.total));
          case (want.status)
            tlpf_pkg::STAT_OK:        if (want.level != tlpf_pkg::LVL_NONE) served++;
            tlpf_pkg::STAT_FULL:      fulls++;
            tlpf_pkg::STAT_EMPTY:     empties++;
            tlpf_pkg::STAT_NOT_FOUND: misses++;
            tlpf_pkg::STAT_BAD_LEVEL: bad_levels++;
            default: begin
            end
          endcase
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited.push_back(apply_request(s_axis_tuser,
                                        s_axis_tdata[KEY_LO +: tlpf_pkg::KEY_W],
                                        s_axis_tdata[AGE_LO +: tlpf_pkg::AGE_W],
                                        s_axis_tdata[LVL_LO +: tlpf_pkg::NLVL_W]));
      end
      fail_count_o      <= fails;
      pending_o         <= awaited.size();
      result_count_o    <= results;
      served_count_o    <= served;
      full_count_o      <= fulls;
      empty_count_o     <= empties;
      miss_count_o      <= misses;
      bad_level_count_o <= bad_levels;
    end
  end

endmodule

### bench/tb_three_level_priority_fifo.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_level_priority_fifo: testbench of the three-level priority FIFO
// Sends a directed set of requests covering empty, full, duplicate keys and
// bad levels, then random request mixes with idle gaps on both channels, a
// long output stall and a full drain pause. The checker scores every result.
// ----------------------------------------------------------------------------
module tb_three_level_priority_fifo;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int unsigned NUM_RANDOM  = 1700;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [tlpf_pkg::REQ_W-1:0]  REQ_UNUSED = 2'd3;
  localparam logic [tlpf_pkg::NLVL_W-1:0] NLVL_ZERO  = 3'd0;
  localparam logic [tlpf_pkg::NLVL_W-1:0] NLVL_HIGH  = tlpf_pkg::NLVL_W'(tlpf_pkg::LVL_HIGH);
  localparam logic [tlpf_pkg::NLVL_W-1:0] NLVL_MED   = tlpf_pkg::NLVL_W'(tlpf_pkg::LVL_MEDIUM);
  localparam logic [tlpf_pkg::NLVL_W-1:0] NLVL_LOW   = tlpf_pkg::NLVL_W'(tlpf_pkg::LVL_LOW);

  logic                           clk_i  = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_valid = 1'b0;
  logic                           s_ready;
  logic [tlpf_pkg::S_TDATA_W-1:0] s_data = '0;
  logic [tlpf_pkg::S_TUSER_W-1:0] s_user = '0;
  logic                           m_valid;
  logic                           m_ready = 1'b0;
  logic [tlpf_pkg::M_TDATA_W-1:0] m_data;
  logic [tlpf_pkg::M_TUSER_W-1:0] m_user;

  int unsigned fail_count, pending, result_count, served_count;
  int unsigned full_count, empty_count, miss_count, bad_level_count;
  int unsigned sent_count;
  int unsigned hold_reqs = 0;
  int unsigned hold_done = 0;
  logic [tlpf_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  three_level_priority_fifo #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user)
  );

  tlpf_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_valid),
    .s_axis_tready    (s_ready),
    .s_axis_tdata     (s_data),
    .s_axis_tuser     (s_user),
    .m_axis_tvalid    (m_valid),
    .m_axis_tready    (m_ready),
    .m_axis_tdata     (m_data),
    .m_axis_tuser     (m_user),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .result_count_o   (result_count),
    .served_count_o   (served_count),
    .full_count_o     (full_count),
    .empty_count_o    (empty_count),
    .miss_count_o     (miss_count),
    .bad_level_count_o(bad_level_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one request and returns after the edge that accepts it. Valid stays
  // high into the next request unless a gap follows.
  task automatic send_req(input logic [tlpf_pkg::REQ_W-1:0]  req,
                          input logic [tlpf_pkg::KEY_W-1:0]  key,
                          input logic [tlpf_pkg::AGE_W-1:0]  age,
                          input logic [tlpf_pkg::NLVL_W-1:0] nlvl,
                          input int unsigned                 gap);
    logic [tlpf_pkg::S_TDATA_W-1:0] word;
    word = '0;
    word[tlpf_pkg::KEY_W-1:0] = key;
    word[tlpf_pkg::KEY_W +: tlpf_pkg::AGE_W] = age;
    word[tlpf_pkg::KEY_W+tlpf_pkg::AGE_W +: tlpf_pkg::NLVL_W] = nlvl;
    s_user  <= req;
    s_data  <= word;
    s_valid <= 1'b1;
    do @(posedge clk_i); while (!s_ready);
    sent_count++;
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin : result_side
    int unsigned run_len;
    int unsigned stall_len;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_done != hold_reqs) begin
        hold_done++;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        run_len = ($urandom_range(9) == 0) ? $urandom_range(50, 150)
                                           : $urandom_range(1, 12);
        stall_len = pick_gap();
        m_ready <= 1'b1;
        repeat (run_len) @(posedge clk_i);
        if (stall_len != 0) begin
          m_ready <= 1'b0;
          repeat (stall_len) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned                 insert_pct;
    int unsigned                 r;
    int unsigned                 pick;
    logic                        burst;
    logic [tlpf_pkg::REQ_W-1:0]  req;
    logic [tlpf_pkg::KEY_W-1:0]  key;
    logic [tlpf_pkg::NLVL_W-1:0] nlvl;
    sent_count = 0;
    insert_pct = 40;
    burst = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue, unused request type, then fill past capacity.
    send_req(tlpf_pkg::REQ_SERVE, '0, '0, NLVL_ZERO, 0);
    send_req(tlpf_pkg::REQ_SET_LEVEL, key_pool[0], '0, NLVL_HIGH, 1);
    send_req(REQ_UNUSED, '1, '1, '1, 0);
    send_req(tlpf_pkg::REQ_INSERT, key_pool[0], '0, NLVL_ZERO, 0);
    send_req(tlpf_pkg::REQ_INSERT, key_pool[1], '1, '1, 2);
    // A second entry with an existing key.
    send_req(tlpf_pkg::REQ_INSERT, key_pool[0], 7'd5, NLVL_ZERO, 0);
    for (int i = 0; i < CAPACITY - 3; i++) begin
      send_req(tlpf_pkg::REQ_INSERT, key_pool[3 + i],
               tlpf_pkg::AGE_W'($urandom_range(127)),
               tlpf_pkg::NLVL_W'($urandom_range(7)), 0);
    end
    send_req(tlpf_pkg::REQ_INSERT, key_pool[2], '1, NLVL_ZERO, 0);
    send_req(tlpf_pkg::REQ_SET_LEVEL, key_pool[0], '0, NLVL_HIGH, 0);
    send_req(tlpf_pkg::REQ_SET_LEVEL, key_pool[1], '0, 3'd7, 0);
    send_req(tlpf_pkg::REQ_SET_LEVEL, key_pool[1], '0, NLVL_MED, 3);
    send_req(tlpf_pkg::REQ_SET_LEVEL, key_pool[2], '0, NLVL_LOW, 0);
    send_req(tlpf_pkg::REQ_SERVE, '0, '0, NLVL_ZERO, 0);
    send_req(tlpf_pkg::REQ_SERVE, '0, '0, NLVL_ZERO, 0);
    send_req(tlpf_pkg::REQ_SERVE, '0, '0, NLVL_ZERO, 0);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // Each stretch leans toward filling, balancing or draining the queue.
      if (i % 150 == 0) begin
        pick = $urandom_range(2);
        insert_pct = (pick == 0) ? 15 : (pick == 1) ? 40 : 65;
        burst = ($urandom_range(3) == 0);
      end
      if (i == 400) hold_reqs++;
      if (i == 900) begin
        s_valid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      r = $urandom_range(99);
      if (r < 3) begin
        req = REQ_UNUSED;
      end else if (r < 3 + insert_pct) begin
        req = tlpf_pkg::REQ_INSERT;
      end else if (r < 3 + insert_pct + (97 - insert_pct) / 2) begin
        req = tlpf_pkg::REQ_SET_LEVEL;
      end else begin
        req = tlpf_pkg::REQ_SERVE;
      end
      key = ($urandom_range(9) == 0) ? tlpf_pkg::KEY_W'($urandom)
                                     : key_pool[$urandom_range(POOL_SIZE - 1)];
      if ($urandom_range(9) == 0) begin
        pick = $urandom_range(4);
        nlvl = (pick == 0) ? NLVL_ZERO : tlpf_pkg::NLVL_W'(3 + pick);
      end else begin
        nlvl = tlpf_pkg::NLVL_W'($urandom_range(tlpf_pkg::LVL_HIGH, tlpf_pkg::LVL_LOW));
      end
      send_req(req, key, tlpf_pkg::AGE_W'($urandom_range(127)), nlvl,
               burst ? 0 : pick_gap());
    end

    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d results: %0d served, %0d full, %0d empty",
             sent_count, result_count, served_count, full_count, empty_count);
    $display("Set-level misses %0d, bad levels %0d; one long output stall, one drain pause",
             miss_count, bad_level_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timed out with %0d results outstanding", pending);
    $display("Regression FAIL");
    $finish;
  end

endmodule
